>>> hdl/rgbhsv_pkg.sv
// shared widths and constants for the rgb to hsv converter
`default_nettype none

package rgbhsv_pkg;

   localparam int CHAN_W        = 8;
   localparam int HUE_W         = 15;
   localparam int DIV_QUOT_W    = 15;
   localparam int HUE_FULL_TURN = 23040;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

`default_nettype wire

>>> hdl/rgbhsv_req_if.sv
// request and response channel interfaces
`default_nettype none

interface rgbhsv_req_if;
   logic                            valid;
   logic                            ready;
   logic [rgbhsv_pkg::CHAN_W-1:0]   red;
   logic [rgbhsv_pkg::CHAN_W-1:0]   green;
   logic [rgbhsv_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rgbhsv_pkg::HUE_W-1:0]    hue;
   logic [rgbhsv_pkg::CHAN_W-1:0]   saturation;
   logic [rgbhsv_pkg::CHAN_W-1:0]   value;

   modport source (output valid, output hue, output saturation, output value, input ready);
   modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/rgbhsv_div.sv
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none

module rgbhsv_div #(
   parameter int DIVISOR_W = rgbhsv_pkg::CHAN_W,
   parameter int QUOT_W    = rgbhsv_pkg::DIV_QUOT_W,
   parameter int SIDE_W    = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [DIVISOR_W+QUOT_W-1:0]   in_dividend,
   input  wire logic [DIVISOR_W-1:0]          in_divisor,
   input  wire logic [SIDE_W-1:0]             in_side,
   output logic                               out_valid,
   output logic [QUOT_W-1:0]                  out_quotient,
   output logic [SIDE_W-1:0]                  out_side
);

   logic                 valid_ff   [QUOT_W];
   logic [DIVISOR_W-1:0] rem_ff     [QUOT_W];
   logic [QUOT_W-1:0]    work_ff    [QUOT_W];
   logic [DIVISOR_W-1:0] divisor_ff [QUOT_W];
   logic [SIDE_W-1:0]    side_ff    [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic                 st_valid;
      logic [DIVISOR_W-1:0] st_rem;
      logic [QUOT_W-1:0]    st_work;
      logic [DIVISOR_W-1:0] st_divisor;
      logic [SIDE_W-1:0]    st_side;
      logic [DIVISOR_W:0]   trial;
      logic [DIVISOR_W:0]   diff;
      logic                 ge;

      if (k == 0) begin : g_first
         // high part of the dividend is already below the divisor
         assign st_valid   = in_valid;
         assign st_rem     = in_dividend[DIVISOR_W+QUOT_W-1:QUOT_W];
         assign st_work    = in_dividend[QUOT_W-1:0];
         assign st_divisor = in_divisor;
         assign st_side    = in_side;
      end else begin : g_next
         assign st_valid   = valid_ff[k-1];
         assign st_rem     = rem_ff[k-1];
         assign st_work    = work_ff[k-1];
         assign st_divisor = divisor_ff[k-1];
         assign st_side    = side_ff[k-1];
      end

      assign trial = {st_rem, st_work[QUOT_W-1]};
      assign diff  = trial - {1'b0, st_divisor};
      assign ge    = (trial >= {1'b0, st_divisor});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= st_valid;
         end
      end

      // quotient bits shift in from the bottom as dividend bits leave the top
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]     <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            work_ff[k]    <= {st_work[QUOT_W-2:0], ge};
            divisor_ff[k] <= st_divisor;
            side_ff[k]    <= st_side;
         end
      end
   end

   assign out_valid    = valid_ff[QUOT_W-1];
   assign out_quotient = work_ff[QUOT_W-1];
   assign out_side     = side_ff[QUOT_W-1];

endmodule

`default_nettype wire

>>> hdl/rgb_to_hsv_converter.sv
// rgb to hsv converter top level
`default_nettype none

// Converts one 8-bit RGB pixel per clock into hue (degrees times 64), saturation
// (255 means 1.0) and value. From request to response a pixel passes through three
// front stages that find max, min, delta and the hue numerator, fifteen stages of
// a restoring divider that produce one quotient bit each for hue and saturation
// side by side, and one output register that applies the wrap of negative hue and
// the grey case. A new request is taken every cycle; when the response is held the
// whole pipeline holds with it.

module rgb_to_hsv_converter (
   input  wire logic         clock,
   input  wire logic         reset,
   rgbhsv_req_if.sink        req_bus,
   rgbhsv_rsp_if.source      rsp_bus
);

   localparam int CW = rgbhsv_pkg::CHAN_W;
   localparam int QW = rgbhsv_pkg::DIV_QUOT_W;
   localparam int DW = CW + QW;
   localparam int NW = CW + 3;

   logic advance;

   // stage a: max, min and winning channel
   logic                   a_valid_ff;
   logic [CW-1:0]          a_red_ff, a_green_ff, a_blue_ff;
   logic [CW-1:0]          a_max_ff, a_min_ff;
   rgbhsv_pkg::sector_type a_sector_ff;
   logic [CW-1:0]          a_max_in, a_min_in, rg_max, rg_min;
   rgbhsv_pkg::sector_type a_sector_in;

   // stage b: delta and channel difference
   logic                   b_valid_ff;
   logic [CW-1:0]          b_value_ff, b_delta_ff;
   logic signed [CW:0]     b_diff_ff;
   rgbhsv_pkg::sector_type b_sector_ff;
   logic signed [CW:0]     b_diff_in;

   // stage c: hue numerator magnitude and sign
   logic                   c_valid_ff;
   logic [CW-1:0]          c_value_ff, c_delta_ff;
   logic                   c_grey_ff;
   logic [NW-1:0]          c_mag_ff;
   logic                   c_neg_ff;
   logic [NW:0]            offset;
   logic signed [NW:0]     num;
   logic [NW:0]            num_abs;

   logic [DW-1:0]          hue_dividend, sat_dividend;

   logic                   sat_valid, hue_valid;
   logic [QW-1:0]          sat_quot, hue_quot;
   logic [CW:0]            sat_side;
   logic                   hue_side;

   logic                              rsp_valid_ff;
   logic [rgbhsv_pkg::HUE_W-1:0]      rsp_hue_ff, rsp_hue_in;
   logic [CW-1:0]                     rsp_sat_ff, rsp_value_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // stage a
   always_comb begin
      rg_max   = (req_bus.red >= req_bus.green) ? req_bus.red : req_bus.green;
      rg_min   = (req_bus.red <= req_bus.green) ? req_bus.red : req_bus.green;
      a_max_in = (rg_max >= req_bus.blue) ? rg_max : req_bus.blue;
      a_min_in = (rg_min <= req_bus.blue) ? rg_min : req_bus.blue;
      // ties go to red, then green
      if (req_bus.red >= req_bus.green && req_bus.red >= req_bus.blue) begin
         a_sector_in = rgbhsv_pkg::SECTOR_RED;
      end else if (req_bus.green >= req_bus.blue) begin
         a_sector_in = rgbhsv_pkg::SECTOR_GREEN;
      end else begin
         a_sector_in = rgbhsv_pkg::SECTOR_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_red_ff    <= req_bus.red;
         a_green_ff  <= req_bus.green;
         a_blue_ff   <= req_bus.blue;
         a_max_ff    <= a_max_in;
         a_min_ff    <= a_min_in;
         a_sector_ff <= a_sector_in;
      end
   end

   // stage b
   always_comb begin
      case (a_sector_ff)
         rgbhsv_pkg::SECTOR_RED:   b_diff_in = $signed({1'b0, a_green_ff}) -
                                               $signed({1'b0, a_blue_ff});
         rgbhsv_pkg::SECTOR_GREEN: b_diff_in = $signed({1'b0, a_blue_ff}) -
                                               $signed({1'b0, a_red_ff});
         default:                  b_diff_in = $signed({1'b0, a_red_ff}) -
                                               $signed({1'b0, a_green_ff});
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_value_ff  <= a_max_ff;
         b_delta_ff  <= a_max_ff - a_min_ff;
         b_diff_ff   <= b_diff_in;
         b_sector_ff <= a_sector_ff;
      end
   end

   // stage c: sector offset times delta plus difference
   always_comb begin
      case (b_sector_ff)
         rgbhsv_pkg::SECTOR_RED:   offset = '0;
         rgbhsv_pkg::SECTOR_GREEN: offset = {3'b000, b_delta_ff, 1'b0};
         default:                  offset = {2'b00, b_delta_ff, 2'b00};
      endcase
      num     = $signed(offset) + $signed({{(NW-CW){b_diff_ff[CW]}}, b_diff_ff});
      num_abs = num[NW] ? (~num + 1'b1) : num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_value_ff <= b_value_ff;
         c_delta_ff <= b_delta_ff;
         c_grey_ff  <= (b_delta_ff == '0);
         c_mag_ff   <= num_abs[NW-1:0];
         c_neg_ff   <= num[NW];
      end
   end

   // 3840 * magnitude and 255 * delta as shift and subtract
   assign hue_dividend = {c_mag_ff, 12'd0} - {4'd0, c_mag_ff, 8'd0};
   assign sat_dividend = {{(QW-CW){1'b0}}, c_delta_ff, 8'd0} - {{QW{1'b0}}, c_delta_ff};

   rgbhsv_div #(
      .DIVISOR_W (CW),
      .QUOT_W    (QW),
      .SIDE_W    (CW + 1)
   ) u_sat_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (c_valid_ff),
      .in_dividend  (sat_dividend),
      .in_divisor   (c_value_ff),
      .in_side      ({c_grey_ff, c_value_ff}),
      .out_valid    (sat_valid),
      .out_quotient (sat_quot),
      .out_side     (sat_side)
   );

   rgbhsv_div #(
      .DIVISOR_W (CW),
      .QUOT_W    (QW),
      .SIDE_W    (1)
   ) u_hue_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (c_valid_ff),
      .in_dividend  (hue_dividend),
      .in_divisor   (c_delta_ff),
      .in_side      (c_neg_ff),
      .out_valid    (hue_valid),
      .out_quotient (hue_quot),
      .out_side     (hue_side)
   );

   // grey pixels give zero hue, negative hue wraps by a full turn, a zero quotient stays zero
   always_comb begin
      if (sat_side[CW]) begin
         rsp_hue_in = '0;
      end else if (hue_side && hue_quot != '0) begin
         rsp_hue_in = rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL_TURN) - hue_quot;
      end else begin
         rsp_hue_in = hue_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sat_valid && hue_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hue_ff   <= rsp_hue_in;
         rsp_sat_ff   <= sat_side[CW] ? '0 : sat_quot[CW-1:0];
         rsp_value_ff <= sat_side[CW-1:0];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hue        = rsp_hue_ff;
   assign rsp_bus.saturation = rsp_sat_ff;
   assign rsp_bus.value      = rsp_value_ff;

endmodule

`default_nettype wire

>>> verif/rgb_to_hsv_converter_test.sv
// self-checking testbench for the rgb to hsv converter: directed pixels, then random streams
module rgb_to_hsv_converter_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HUE_SIXTH    = 3840;
   localparam int QUIET_LIMIT  = 2000;
   localparam int LONG_STALL   = 300;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [rgbhsv_pkg::CHAN_W-1:0] red;
      logic [rgbhsv_pkg::CHAN_W-1:0] green;
      logic [rgbhsv_pkg::CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [rgbhsv_pkg::HUE_W-1:0]  hue;
      logic [rgbhsv_pkg::CHAN_W-1:0] saturation;
      logic [rgbhsv_pkg::CHAN_W-1:0] value;
   } hsv_type;

   typedef struct packed {
      pixel_type px;
      logic      known;
      hsv_type   hsv;
   } directed_row_type;

   typedef struct packed {
      pixel_type px;
      hsv_type   hsv;
   } pending_type;

   logic clock;
   logic reset;

   rgbhsv_req_if req_bus ();
   rgbhsv_rsp_if rsp_bus ();

   rgb_to_hsv_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pending_type pending_hsv [$];
   int          error_count   = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 9;
   int          rsp_idle_pct  = 51;
   int          stall_trigger = 0;
   int          stall_seen    = 0;
   int          stall_left    = 0;
   pending_type oldest;

   // columns: red, green, blue, known, hue, saturation, value
   directed_row_type directed_rows [0:23] = '{
      {8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     8'd0,   8'd0},
      {8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     8'd0,   8'd255},
      {8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     8'd0,   8'd128},
      {8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     8'd0,   8'd1},
      {8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     8'd255, 8'd255},
      {8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  8'd255, 8'd255},
      {8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 8'd255, 8'd255},
      {8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  8'd255, 8'd255},
      {8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 8'd255, 8'd255},
      {8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 8'd255, 8'd255},
      {8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     8'd255, 8'd1},
      {8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     8'd0,   8'd0},
      {8'd255, 8'd254, 8'd255, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd255, 8'd254, 8'd254, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd2,   8'd1,   8'd1,   1'b0, 15'd0,     8'd0,   8'd0},
      {8'd0,   8'd1,   8'd0,   1'b0, 15'd0,     8'd0,   8'd0},
      {8'd100, 8'd50,  8'd200, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd200, 8'd100, 8'd50,  1'b0, 15'd0,     8'd0,   8'd0},
      {8'd50,  8'd200, 8'd100, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd254, 8'd255, 8'd0,   1'b0, 15'd0,     8'd0,   8'd0},
      {8'd0,   8'd254, 8'd255, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd170, 8'd255, 8'd85,  1'b0, 15'd0,     8'd0,   8'd0},
      {8'd127, 8'd128, 8'd129, 1'b0, 15'd0,     8'd0,   8'd0},
      {8'd1,   8'd255, 8'd254, 1'b0, 15'd0,     8'd0,   8'd0}
   };

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic hsv_type predict_hsv(pixel_type px);
      int                     r, g, b, top, bottom, delta, num, h, s;
      rgbhsv_pkg::sector_type sector;
      hsv_type                res;
      r = px.red;
      g = px.green;
      b = px.blue;
      top = (r > g) ? r : g;
      top = (top > b) ? top : b;
      bottom = (r < g) ? r : g;
      bottom = (bottom < b) ? bottom : b;
      delta = top - bottom;
      if (delta == 0) begin
         h = 0;
         s = 0;
      end else begin
         s = (255 * delta) / top;
         // ties go to the earlier channel
         if (r == top) sector = rgbhsv_pkg::SECTOR_RED;
         else if (g == top) sector = rgbhsv_pkg::SECTOR_GREEN;
         else sector = rgbhsv_pkg::SECTOR_BLUE;
         case (sector)
            rgbhsv_pkg::SECTOR_RED: begin
               num = g - b;
            end
            rgbhsv_pkg::SECTOR_GREEN: begin
               num = 2 * delta + (b - r);
            end
            default: begin
               num = 4 * delta + (r - g);
            end
         endcase
         // signed int division truncates toward zero
         h = (HUE_SIXTH * num) / delta;
         if (h < 0) h += rgbhsv_pkg::HUE_FULL_TURN;
      end
      res.hue        = h[rgbhsv_pkg::HUE_W-1:0];
      res.saturation = s[rgbhsv_pkg::CHAN_W-1:0];
      res.value      = top[rgbhsv_pkg::CHAN_W-1:0];
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type                     px;
      logic [rgbhsv_pkg::CHAN_W-1:0] hi, lo;
      logic [31:0]                   pick;
      px.red   = 8'($urandom);
      px.green = 8'($urandom);
      px.blue  = 8'($urandom);
      hi = 8'($urandom);
      lo = 8'($urandom_range(hi));
      pick = $urandom;
      case ($urandom_range(9))
         0: begin
            px.green = px.red;
            px.blue  = px.red;
         end
         1: begin
            // two channels share the maximum
            case (pick[1:0])
               2'd0: px = '{hi, hi, lo};
               2'd1: px = '{lo, hi, hi};
               default: px = '{hi, lo, hi};
            endcase
         end
         2: begin
            // each channel one of 0, 1, 254, 255
            px.red   = {8{pick[0]}} ^ {7'd0, pick[1]};
            px.green = {8{pick[2]}} ^ {7'd0, pick[3]};
            px.blue  = {8{pick[4]}} ^ {7'd0, pick[5]};
         end
         3: begin
            px.green = px.red + 8'(pick[1:0]) - 8'd1;
            px.blue  = px.red ^ {6'd0, pick[3:2]};
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic report_mismatch(string detail);
      $display("mismatch at %0t: %s", $realtime, detail);
      error_count++;
   endtask

   task automatic send_pixel(pixel_type px, hsv_type hsv);
      pending_type entry;
      req_bus.valid <= 1'b1;
      req_bus.red   <= px.red;
      req_bus.green <= px.green;
      req_bus.blue  <= px.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      entry.px  = px;
      entry.hsv = hsv;
      pending_hsv.push_back(entry);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random(int count, int stall_at);
      pixel_type px;
      for (int i = 0; i < count; i++) begin
         if (i == stall_at) stall_trigger <= stall_trigger + 1;
         px = random_pixel();
         send_pixel(px, predict_hsv(px));
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   // receiver: random holds, plus one long hold on request from the stimulus
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_trigger != stall_seen) begin
         stall_seen    <= stall_trigger;
         stall_left    <= LONG_STALL;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_hsv.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest = pending_hsv.pop_front();
            if (rsp_bus.hue !== oldest.hsv.hue)
               report_mismatch($sformatf("rgb %0d %0d %0d hue %0d, expected %0d",
                  oldest.px.red, oldest.px.green, oldest.px.blue,
                  rsp_bus.hue, oldest.hsv.hue));
            if (rsp_bus.saturation !== oldest.hsv.saturation)
               report_mismatch($sformatf("rgb %0d %0d %0d saturation %0d, expected %0d",
                  oldest.px.red, oldest.px.green, oldest.px.blue,
                  rsp_bus.saturation, oldest.hsv.saturation));
            if (rsp_bus.value !== oldest.hsv.value)
               report_mismatch($sformatf("rgb %0d %0d %0d value %0d, expected %0d",
                  oldest.px.red, oldest.px.green, oldest.px.blue,
                  rsp_bus.value, oldest.hsv.value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rgb_to_hsv_converter test failed");
            $finish;
         end
      end
   end

   initial begin
      hsv_type hsv;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      rsp_bus.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         hsv = directed_rows[i].known ? directed_rows[i].hsv : predict_hsv(directed_rows[i].px);
         send_pixel(directed_rows[i].px, hsv);
      end
      send_random(260, -1);
      // sender waits for the pipeline to empty
      drain_results();

      send_idle_pct = 51;
      rsp_idle_pct <= 9;
      send_random(280, -1);

      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      // long receiver hold while requests keep coming
      send_random(310, 60);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("rgb_to_hsv_converter test passed");
      end else begin
         $display("rgb_to_hsv_converter test failed");
      end
      $finish;
   end

endmodule
